[rtl/tce_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tce_pkg: shared definitions of the text console engine
// field widths, operation and character codes, sweep modes and the
// command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package tce_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  localparam int OP_W   = 3;
  localparam int CH_W   = 8;
  localparam int ATTR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;

  localparam int TAB_STEP = 4;

  localparam logic [OP_W-1:0] OP_WRITE     = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd1;
  localparam logic [OP_W-1:0] OP_FILL      = 3'd2;
  localparam logic [OP_W-1:0] OP_SCROLL_DN = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_ATTR  = 3'd4;
  localparam logic [OP_W-1:0] OP_READ      = 3'd5;

  localparam logic [CH_W-1:0] CH_BS    = 8'd8;
  localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CH_W-1:0] CH_NL    = 8'd10;
  localparam logic [CH_W-1:0] CH_CR    = 8'd13;
  localparam logic [CH_W-1:0] CH_SPACE = 8'd32;

  localparam logic [ATTR_W-1:0] ATTR_RST = 8'd15;

  typedef enum logic [2:0] {
    SWM_ZERO,
    SWM_BLANK,
    SWM_FILL,
    SWM_UP,
    SWM_DOWN
  } sweep_mode_e;

  typedef struct packed {
    logic        latch;
    logic        sweep_start;
    sweep_mode_e sweep_mode;
    logic        sweep_step;
    logic        put;
    logic        put_blank;
    logic        col_clr;
    logic        col_inc;
    logic        col_dec;
    logic        col_last;
    logic        row_clr;
    logic        row_inc;
    logic        row_dec;
    logic        attr_set;
    logic        attr_dflt;
    logic        tab_load;
    logic        val_load;
    logic        out_load;
  } tce_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            is_nl;
    logic            is_cr;
    logic            is_bs;
    logic            is_tab;
    logic            col_zero;
    logic            col_full;
    logic            row_zero;
    logic            row_last;
    logic            tab_more;
    logic            sweep_last;
    logic            wr_busy;
    logic            out_free;
  } tce_sts_t;

endpackage
`default_nettype wire

[rtl/tce_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tce_if: valid/ready channels of the text console engine
// tce_in_if carries operations, tce_out_if carries results
// ----------------------------------------------------------------------------
interface tce_in_if import tce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CH_W-1:0]   char_code;
  logic [ATTR_W-1:0] attribute;
  logic [ROW_W-1:0]  cell_row;
  logic [COL_W-1:0]  cell_col;

  modport source (
    output valid, operation, char_code, attribute, cell_row, cell_col,
    input  ready
  );
  modport sink (
    input  valid, operation, char_code, attribute, cell_row, cell_col,
    output ready
  );
endinterface

interface tce_out_if import tce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;

  modport source (
    output valid, cell_value, cursor_row, cursor_col,
    input  ready
  );
  modport sink (
    input  valid, cell_value, cursor_row, cursor_col,
    output ready
  );
endinterface
`default_nettype wire

[rtl/text_console_engine_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_engine_core: character terminal engine
// rows x columns store of 16-bit cells with cursor and current attribute
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake      payload
//  in_i      sink       valid/ready    operation, char_code, attribute,
//                                      cell_row, cell_col
//  out_o     source     valid/ready    cell_value, cursor_row, cursor_col
//  cfg       write only cfg_we_i       cfg_data_i -> default attribute
//
//  one transaction in, one transaction out; items are handled one at a time
//  a printable or tab on a full row first adds the newline; clear, fill,
//  scroll down and a newline on the last row walk the whole cell memory
//  through its single read and write port; after reset a clearing pass
//  zeroes ROWS*COLS cells before in_i.ready rises; a result waiting on out_o
//  does not stop the next accept, only the hand-off of that item's own result
//
module text_console_engine_core import tce_pkg::*; #(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire  [ATTR_W-1:0] cfg_data_i,
  tce_in_if.sink            in_i,
  tce_out_if.source         out_o
);

  tce_cmd_t cmd;
  tce_sts_t sts;

  // sequencer: decodes the item and steps the datapath
  tce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // cell memory, cursor, attributes and the result register
  tce_dp #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .op_i         (in_i.operation),
    .ch_i         (in_i.char_code),
    .attr_i       (in_i.attribute),
    .row_i        (in_i.cell_row),
    .col_i        (in_i.cell_col),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .cell_value_o (out_o.cell_value),
    .cursor_row_o (out_o.cursor_row),
    .cursor_col_o (out_o.cursor_col)
  );

  // a single cell put must never collide with a pending sweep write
  a_no_wr_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.put && sts.wr_busy))
    else $error("cell put collides with sweep write");

  // one item at a time: ready drops right after an accepted transaction
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while an item is in flight");

  // a sweep ends after its last address
  a_sweep_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.sweep_step && sts.sweep_last) |=> !cmd.sweep_step)
    else $error("sweep ran past its last address");

  // reported cursor row stays on the screen
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (int'(out_o.cursor_row) < ROWS))
    else $error("cursor row out of range");

endmodule
`default_nettype wire

[rtl/tce_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tce_dp: datapath of the text console engine
// cell memory, cursor, attributes, sweep address counter and result register
// ----------------------------------------------------------------------------
module tce_dp import tce_pkg::*; #(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  tce_cmd_t          cmd_i,
  output tce_sts_t          sts_o,
  input  wire               cfg_we_i,
  input  wire [ATTR_W-1:0]  cfg_data_i,
  input  wire [OP_W-1:0]    op_i,
  input  wire [CH_W-1:0]    ch_i,
  input  wire [ATTR_W-1:0]  attr_i,
  input  wire [ROW_W-1:0]   row_i,
  input  wire [COL_W-1:0]   col_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [CELL_W-1:0] cell_value_o,
  output logic [ROW_W-1:0]  cursor_row_o,
  output logic [COL_W-1:0]  cursor_col_o
);

  localparam int N   = ROWS * COLS;
  localparam int AW  = $clog2(N);
  localparam int CLW = $clog2(COLS + 1);
  localparam int RLW = $clog2(ROWS);
  localparam int TW  = CLW + 1;

  // latched item
  logic [OP_W-1:0]   op_q;
  logic [CH_W-1:0]   ch_q;
  logic [ATTR_W-1:0] attr_in_q;
  logic [ROW_W-1:0]  crow_q;
  logic [COL_W-1:0]  ccol_q;

  logic [RLW-1:0]    row_q, row_d;
  logic [CLW-1:0]    col_q, col_d;
  logic [CLW-1:0]    stop_q;
  logic [ATTR_W-1:0] cur_attr_q, dflt_q;

  logic [AW-1:0]     cnt_q, cnt_d;
  sweep_mode_e       mode_q;
  logic              pv_q, puse_q;
  logic [AW-1:0]     pa_q;

  logic [CELL_W-1:0] mem_q [N];
  logic [CELL_W-1:0] rd_q;
  logic [CELL_W-1:0] val_q;

  logic              out_valid_q;
  logic [CELL_W-1:0] out_value_q;
  logic [RLW-1:0]    out_row_q;
  logic [CLW-1:0]    out_col_q;

  logic [AW-1:0]     cur_addr, cell_addr, src_addr, raddr, waddr;
  logic              src_use, we, cell_ok;
  logic [CELL_W-1:0] wdata, blank;
  logic [TW-1:0]     col_ext, tab_next;
  logic [CLW-1:0]    tab_stop;

  assign cur_addr  = AW'(AW'(row_q) * AW'(COLS)) + AW'(col_q);
  assign cell_addr = AW'(AW'(crow_q) * AW'(COLS)) + AW'(ccol_q);
  assign cell_ok   = (6'(crow_q) < 6'(ROWS)) && (8'(ccol_q) < 8'(COLS));
  assign blank     = {cur_attr_q, CH_SPACE};

  // next multiple of the tab step, capped at the row end
  assign col_ext  = TW'(col_q);
  assign tab_next = col_ext + TW'(TAB_STEP) - (col_ext % TW'(TAB_STEP));
  assign tab_stop = (tab_next > TW'(COLS)) ? CLW'(COLS) : CLW'(tab_next);

  // sweep source address
  always_comb begin
    src_addr = cnt_q;
    src_use  = 1'b0;
    case (mode_q)
      SWM_UP: begin
        src_addr = AW'(cnt_q + AW'(COLS));
        src_use  = (cnt_q < AW'(N - COLS));
      end
      SWM_DOWN: begin
        src_addr = AW'(cnt_q - AW'(COLS));
        src_use  = (cnt_q >= AW'(COLS));
      end
      SWM_FILL: begin
        src_use = 1'b1;
      end
      default: begin
        src_use = 1'b0;
      end
    endcase
  end

  assign raddr = cmd_i.sweep_step ? src_addr : cell_addr;

  // write port: sweep pipeline first, then single cell puts
  always_comb begin
    we    = 1'b0;
    waddr = pa_q;
    wdata = '0;
    if (pv_q) begin
      we = 1'b1;
      case (mode_q) inside
        SWM_FILL:         wdata = {attr_in_q, rd_q[CH_W-1:0]};
        SWM_UP, SWM_DOWN: wdata = puse_q ? rd_q : blank;
        SWM_BLANK:        wdata = blank;
        default:          wdata = '0;
      endcase
    end else if (cmd_i.put) begin
      we    = 1'b1;
      waddr = cur_addr;
      wdata = {cur_attr_q, (cmd_i.put_blank ? CH_SPACE : ch_q)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q      <= op_i;
      ch_q      <= ch_i;
      attr_in_q <= attr_i;
      crow_q    <= row_i;
      ccol_q    <= col_i;
    end
    if (cmd_i.tab_load) begin
      stop_q <= tab_stop;
    end
    pa_q   <= cnt_q;
    puse_q <= src_use;
    if (cmd_i.latch) begin
      val_q <= '0;
    end else if (cmd_i.val_load) begin
      val_q <= cell_ok ? rd_q : '0;
    end
    if (cmd_i.out_load) begin
      out_value_q <= val_q;
      out_row_q   <= row_q;
      out_col_q   <= col_q;
    end
  end

  always_comb begin
    row_d = row_q;
    if (cmd_i.row_clr) begin
      row_d = '0;
    end else if (cmd_i.row_inc) begin
      row_d = row_q + 1'b1;
    end else if (cmd_i.row_dec) begin
      row_d = row_q - 1'b1;
    end
    col_d = col_q;
    if (cmd_i.col_clr) begin
      col_d = '0;
    end else if (cmd_i.col_inc) begin
      col_d = col_q + 1'b1;
    end else if (cmd_i.col_dec) begin
      col_d = col_q - 1'b1;
    end else if (cmd_i.col_last) begin
      col_d = CLW'(COLS - 1);
    end
    cnt_d = cnt_q;
    if (cmd_i.sweep_start) begin
      cnt_d = (cmd_i.sweep_mode == SWM_DOWN) ? AW'(N - 1) : '0;
    end else if (cmd_i.sweep_step) begin
      cnt_d = (mode_q == SWM_DOWN) ? cnt_q - 1'b1 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      cur_attr_q  <= ATTR_RST;
      dflt_q      <= ATTR_RST;
      cnt_q       <= '0;
      mode_q      <= SWM_ZERO;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      cnt_q <= cnt_d;
      pv_q  <= cmd_i.sweep_step;
      if (cmd_i.sweep_start) begin
        mode_q <= cmd_i.sweep_mode;
      end
      if (cmd_i.attr_dflt) begin
        cur_attr_q <= dflt_q;
      end else if (cmd_i.attr_set) begin
        cur_attr_q <= attr_in_q;
      end
      if (cfg_we_i) begin
        dflt_q <= cfg_data_i;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.op         = op_q;
    sts_o.is_nl      = (ch_q == CH_NL);
    sts_o.is_cr      = (ch_q == CH_CR);
    sts_o.is_bs      = (ch_q == CH_BS);
    sts_o.is_tab     = (ch_q == CH_TAB);
    sts_o.col_zero   = (col_q == '0);
    sts_o.col_full   = (col_q >= CLW'(COLS));
    sts_o.row_zero   = (row_q == '0);
    sts_o.row_last   = (row_q == RLW'(ROWS - 1));
    sts_o.tab_more   = (col_q < stop_q);
    sts_o.sweep_last = (mode_q == SWM_DOWN) ? (cnt_q == '0) : (cnt_q == AW'(N - 1));
    sts_o.wr_busy    = pv_q;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign cell_value_o = out_value_q;
  assign cursor_row_o = ROW_W'(out_row_q);
  assign cursor_col_o = COL_W'(out_col_q);

endmodule
`default_nettype wire

[rtl/tce_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tce_ctrl: controller of the text console engine
// sequences each operation as cell puts, memory sweeps and cursor moves
// ----------------------------------------------------------------------------
module tce_ctrl import tce_pkg::*; (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      in_valid_i,
  output logic     in_ready_o,
  input  tce_sts_t sts_i,
  output tce_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INIT    = 4'd1;
  localparam logic [3:0] S_DECODE  = 4'd2;
  localparam logic [3:0] S_NL      = 4'd3;
  localparam logic [3:0] S_NL_END  = 4'd4;
  localparam logic [3:0] S_SWEEP   = 4'd5;
  localparam logic [3:0] S_FLUSH   = 4'd6;
  localparam logic [3:0] S_BS      = 4'd7;
  localparam logic [3:0] S_BS_PUT  = 4'd8;
  localparam logic [3:0] S_PUT     = 4'd9;
  localparam logic [3:0] S_TAB_SET = 4'd10;
  localparam logic [3:0] S_TAB     = 4'd11;
  localparam logic [3:0] S_READ    = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  logic [3:0] state_q, state_d;
  logic       init_q, init_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    init_d  = init_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_INIT: begin
        cmd_o.sweep_start = 1'b1;
        cmd_o.sweep_mode  = SWM_ZERO;
        state_d           = S_SWEEP;
      end
      S_DECODE: begin
        unique case (sts_i.op)
          OP_WRITE: begin
            if (sts_i.is_nl) begin
              state_d = S_NL;
            end else if (sts_i.is_cr) begin
              cmd_o.col_clr = 1'b1;
              state_d       = S_DONE;
            end else if (sts_i.is_bs) begin
              state_d = (sts_i.col_zero && sts_i.row_zero) ? S_DONE : S_BS;
            end else if (sts_i.col_full) begin
              state_d = S_NL;
            end else begin
              state_d = sts_i.is_tab ? S_TAB_SET : S_PUT;
            end
          end
          OP_CLEAR: begin
            cmd_o.row_clr     = 1'b1;
            cmd_o.col_clr     = 1'b1;
            cmd_o.attr_dflt   = 1'b1;
            cmd_o.sweep_start = 1'b1;
            cmd_o.sweep_mode  = SWM_BLANK;
            state_d           = S_SWEEP;
          end
          OP_FILL: begin
            cmd_o.sweep_start = 1'b1;
            cmd_o.sweep_mode  = SWM_FILL;
            state_d           = S_SWEEP;
          end
          OP_SCROLL_DN: begin
            cmd_o.sweep_start = 1'b1;
            cmd_o.sweep_mode  = SWM_DOWN;
            state_d           = S_SWEEP;
          end
          OP_SET_ATTR: begin
            cmd_o.attr_set = 1'b1;
            state_d        = S_DONE;
          end
          OP_READ: begin
            state_d = S_READ;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_NL: begin
        if (sts_i.row_last) begin
          cmd_o.sweep_start = 1'b1;
          cmd_o.sweep_mode  = SWM_UP;
          state_d           = S_SWEEP;
        end else begin
          cmd_o.row_inc = 1'b1;
          state_d       = S_NL_END;
        end
      end
      S_NL_END: begin
        cmd_o.col_clr = 1'b1;
        if (sts_i.is_nl) begin
          state_d = S_DONE;
        end else begin
          state_d = sts_i.is_tab ? S_TAB_SET : S_PUT;
        end
      end
      S_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // last sweep write lands in this cycle
        if (init_q) begin
          init_d  = 1'b0;
          state_d = S_IDLE;
        end else if (sts_i.op == OP_WRITE) begin
          state_d = S_NL_END;
        end else begin
          state_d = S_DONE;
        end
      end
      S_BS: begin
        if (sts_i.col_zero) begin
          cmd_o.row_dec  = 1'b1;
          cmd_o.col_last = 1'b1;
        end else begin
          cmd_o.col_dec = 1'b1;
        end
        state_d = S_BS_PUT;
      end
      S_BS_PUT: begin
        cmd_o.put       = 1'b1;
        cmd_o.put_blank = 1'b1;
        state_d         = S_DONE;
      end
      S_PUT: begin
        cmd_o.put     = 1'b1;
        cmd_o.col_inc = 1'b1;
        state_d       = S_DONE;
      end
      S_TAB_SET: begin
        cmd_o.tab_load = 1'b1;
        state_d        = S_TAB;
      end
      S_TAB: begin
        if (sts_i.tab_more) begin
          cmd_o.put       = 1'b1;
          cmd_o.put_blank = 1'b1;
          cmd_o.col_inc   = 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_READ: begin
        cmd_o.val_load = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      init_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
    end
  end

endmodule
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: text console engine testbench
// a short directed command list, then random command streams over several
// default-attribute settings; every status transaction from the engine is
// compared field by field against a screen model kept in the testbench
// ----------------------------------------------------------------------------
module tb_top;
  import tce_pkg::*;

  // screen geometry matches the engine's default parameters
  localparam int NCOL  = COLS_DEF;
  localparam int NROW  = ROWS_DEF;
  localparam int NCELL = NCOL * NROW;

  // stimulus plan: one directed block, then five settings of the default
  // attribute (reset value, all zeros, all ones, two random values)
  localparam int N_PHASES    = 5;
  localparam int PHASE_ITEMS = 330;

  // the slowest legal run is every command walking the whole store behind the
  // longest gaps and stalls; the limit allows several times that
  localparam int SETTLE_CYCLES  = 16;
  localparam int CYCLE_LIMIT    = 15_000_000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CH_W-1:0]   ch;
    logic [ATTR_W-1:0] attr;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } console_cmd_t;

  typedef struct packed {
    logic [CELL_W-1:0] value;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } console_status_t;

  // --------------------------------------------------------------------------
  // clock, reset and the engine
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic              cfg_we   = 1'b0;
  logic [ATTR_W-1:0] cfg_data = '0;

  // driver side state, all known from time zero
  logic         drv_valid = 1'b0;
  console_cmd_t drv_cmd   = '0;
  logic         out_rdy   = 1'b0;

  tce_in_if  in_if ();
  tce_out_if out_if ();

  assign in_if.valid     = drv_valid;
  assign in_if.operation = drv_cmd.op;
  assign in_if.char_code = drv_cmd.ch;
  assign in_if.attribute = drv_cmd.attr;
  assign in_if.cell_row  = drv_cmd.row;
  assign in_if.cell_col  = drv_cmd.col;
  assign out_if.ready    = out_rdy;

  text_console_engine_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // --------------------------------------------------------------------------
  // screen model: cell store, cursor and attributes
  // --------------------------------------------------------------------------
  logic [CELL_W-1:0] scr_mem [NCELL];
  int unsigned       mdl_row;
  int unsigned       mdl_col;
  logic [ATTR_W-1:0] mdl_attr;
  logic [ATTR_W-1:0] mdl_dflt;

  // what the run went through, for the summary
  int unsigned n_scroll_up = 0;
  int unsigned n_wrap      = 0;
  int unsigned n_read_hit  = 0;

  function automatic void put_word(int unsigned r, int unsigned c, logic [CELL_W-1:0] w);
    if (r < NROW && c < NCOL) scr_mem[r * NCOL + c] = w;
  endfunction

  // newline on the last row moves every row up and blanks the bottom one
  function automatic void shift_rows_up();
    for (int i = 0; i < (NROW - 1) * NCOL; i++) scr_mem[i] = scr_mem[i + NCOL];
    for (int i = 0; i < NCOL; i++) scr_mem[(NROW - 1) * NCOL + i] = {mdl_attr, CH_SPACE};
    n_scroll_up++;
  endfunction

  // bottom row is lost, top row blanked with the current attribute
  function automatic void shift_rows_down();
    for (int i = (NROW - 1) * NCOL; i > 0; i--) scr_mem[i + NCOL - 1] = scr_mem[i - 1];
    for (int i = 0; i < NCOL; i++) scr_mem[i] = {mdl_attr, CH_SPACE};
  endfunction

  function automatic void line_feed();
    if (mdl_row < NROW - 1) mdl_row++;
    else shift_rows_up();
    mdl_col = 0;
  endfunction

  function automatic void put_char(logic [CH_W-1:0] ch);
    int unsigned stop_col;
    case (ch)
      CH_NL: line_feed();
      CH_CR: mdl_col = 0;
      CH_BS: begin
        // top-left: nothing moves and nothing is blanked
        if (mdl_col == 0) begin
          if (mdl_row == 0) return;
          mdl_row--;
          mdl_col = NCOL;
        end
        mdl_col--;
        put_word(mdl_row, mdl_col, {mdl_attr, CH_SPACE});
      end
      CH_TAB: begin
        if (mdl_col >= NCOL) begin
          line_feed();
          n_wrap++;
        end
        stop_col = mdl_col + (TAB_STEP - mdl_col % TAB_STEP);
        if (stop_col > NCOL) stop_col = NCOL;
        while (mdl_col < stop_col) begin
          put_word(mdl_row, mdl_col, {mdl_attr, CH_SPACE});
          mdl_col++;
        end
      end
      default: begin
        // printable, character zero included; a full row wraps first
        if (mdl_col >= NCOL) begin
          line_feed();
          n_wrap++;
        end
        put_word(mdl_row, mdl_col, {mdl_attr, ch});
        mdl_col++;
      end
    endcase
  endfunction

  // applies one command to the model and returns the status it must produce
  function automatic console_status_t console_apply(console_cmd_t c);
    console_status_t s;
    s.value = '0;
    case (c.op)
      OP_WRITE: put_char(c.ch);
      OP_CLEAR: begin
        mdl_row  = 0;
        mdl_col  = 0;
        mdl_attr = mdl_dflt;
        for (int i = 0; i < NCELL; i++) scr_mem[i] = {mdl_dflt, CH_SPACE};
      end
      OP_FILL: begin
        for (int i = 0; i < NCELL; i++) scr_mem[i] = {c.attr, scr_mem[i][CH_W-1:0]};
      end
      OP_SCROLL_DN: shift_rows_down();
      OP_SET_ATTR:  mdl_attr = c.attr;
      OP_READ: begin
        // out-of-range coordinates read as zero
        if (c.row < NROW && c.col < NCOL) begin
          s.value = scr_mem[c.row * NCOL + c.col];
          n_read_hit++;
        end
      end
      default: ;
    endcase
    s.row = ROW_W'(mdl_row);
    s.col = COL_W'(mdl_col);
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // command backlog and stimulus builders
  // --------------------------------------------------------------------------
  console_cmd_t    cmd_backlog [$];
  console_status_t pending_status [$];

  int unsigned n_pushed = 0;  // every command queued
  int unsigned n_useful = 0;  // commands that are not plain no-ops

  function automatic void queue_cmd(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
                                    logic [ATTR_W-1:0] attr, logic [ROW_W-1:0] r,
                                    logic [COL_W-1:0] c);
    cmd_backlog.push_back('{op: op, ch: ch, attr: attr, row: r, col: c});
    n_pushed++;
    if (op <= OP_READ) n_useful++;
  endfunction

  // unused fields of a command carry random values
  function automatic void queue_op(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
                                   logic [ATTR_W-1:0] attr);
    queue_cmd(op, ch, attr, ROW_W'($urandom()), COL_W'($urandom()));
  endfunction

  function automatic void queue_char(logic [CH_W-1:0] ch);
    queue_op(OP_WRITE, ch, ATTR_W'($urandom()));
  endfunction

  function automatic void queue_read(int unsigned r, int unsigned c);
    queue_cmd(OP_READ, CH_W'($urandom()), ATTR_W'($urandom()), ROW_W'(r), COL_W'(c));
  endfunction

  // one random episode: mostly text with edits, newline runs and reads,
  // with a little noise and the occasional full-store operation
  function automatic void random_episode();
    int unsigned pick;
    logic [CH_W-1:0] ch;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // a line of text, long enough at times to wrap
      repeat ($urandom_range(1, 90)) begin
        case ($urandom_range(0, 19))
          0:       ch = CH_TAB;
          1:       ch = CH_BS;
          2:       ch = CH_CR;
          default: ch = CH_W'($urandom_range(0, 255));
        endcase
        queue_char(ch);
      end
    end else if (pick < 50) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 1) != 0) queue_char(CH_CR);
        queue_char(CH_NL);
      end
    end else if (pick < 70) begin
      // reads, mostly on screen, some anywhere the fields reach
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 4) == 0)
          queue_read($urandom_range(0, 31), $urandom_range(0, 127));
        else
          queue_read($urandom_range(0, NROW - 1), $urandom_range(0, NCOL - 1));
      end
    end else if (pick < 80) begin
      // backspace runs walk back across row boundaries
      repeat ($urandom_range(1, 12)) queue_char(CH_BS);
    end else if (pick < 87) begin
      queue_op(OP_SET_ATTR, CH_W'($urandom()), ATTR_W'($urandom()));
    end else if (pick < 90) begin
      queue_op(OP_W'($urandom_range(OP_CLEAR, OP_SCROLL_DN)), CH_W'($urandom()),
               ATTR_W'($urandom()));
    end else if (pick < 95) begin
      // noise: any operation code, unused ones included
      repeat ($urandom_range(1, 4))
        queue_cmd(OP_W'($urandom()), CH_W'($urandom()), ATTR_W'($urandom()),
                  ROW_W'($urandom()), COL_W'($urandom()));
    end else begin
      // long newline run, reaches the bottom row and scrolls
      repeat ($urandom_range(20, 30)) queue_char(CH_NL);
    end
  endfunction

  // --------------------------------------------------------------------------
  // driver: bursts of commands with random gaps between them
  // --------------------------------------------------------------------------
  logic        in_taken    = 1'b0;  // transaction at the last rising edge
  int unsigned burst_left  = 0;
  int unsigned gap_left    = 0;

  always @(negedge clk_i) begin
    // an offered command stays on the channel until it is taken
    if (rst_ni && !(drv_valid && !in_taken)) begin
      if (gap_left != 0) begin
        drv_valid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (cmd_backlog.size() != 0) begin
        drv_cmd   <= cmd_backlog.pop_front();
        drv_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          // a third of the bursts run straight into the next one
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: stall pattern that cycles through four styles, plus long
  // hold-offs during which the engine fills up and stops taking commands
  // --------------------------------------------------------------------------
  logic [9:0]  stall_tick    = '0;
  int unsigned holdoff_left  = 0;
  int unsigned holdoffs_done = 0;
  int unsigned n_accepted    = 0;

  always @(negedge clk_i) begin
    stall_tick <= stall_tick + 1'b1;
    if (holdoff_left != 0) begin
      out_rdy <= 1'b0;
    end else begin
      case (stall_tick[9:8])
        2'd0:    out_rdy <= 1'b1;
        2'd1:    out_rdy <= (stall_tick[1:0] != 2'd3);
        2'd2:    out_rdy <= 1'($urandom_range(0, 1));
        default: out_rdy <= (stall_tick[2:0] == 3'd0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end else if (holdoffs_done < 2 &&
                 n_accepted >= ((holdoffs_done == 0) ? 200 : 900)) begin
      holdoff_left  <= HOLDOFF_CYCLES;
      holdoffs_done <= holdoffs_done + 1;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predicts on every command transaction, checks every status
  // transaction against the oldest prediction
  // --------------------------------------------------------------------------
  int unsigned n_results = 0;
  int unsigned n_errors  = 0;
  int unsigned n_cycles  = 0;

  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("mismatch on %s: expected %0d, got %0d (result %0d)",
               what, want, got, n_results);
  endfunction

  always @(posedge clk_i) begin
    console_status_t want;
    in_taken <= in_if.valid && in_if.ready;
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               n_cycles, pending_status.size());
      $display("FAILED: results differ");
      $finish;
    end else if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        n_results <= n_results + 1;
        if (pending_status.size() == 0) begin
          note_mismatch("unexpected status, cursor column", 0, out_if.cursor_col);
        end else begin
          want = pending_status.pop_front();
          if (out_if.cell_value !== want.value)
            note_mismatch("cell_value", want.value, out_if.cell_value);
          if (out_if.cursor_row !== want.row)
            note_mismatch("cursor_row", want.row, out_if.cursor_row);
          if (out_if.cursor_col !== want.col)
            note_mismatch("cursor_col", want.col, out_if.cursor_col);
        end
      end
      // a command's status can never leave on the edge that takes it
      if (in_if.valid && in_if.ready) begin
        pending_status.push_back(console_apply(drv_cmd));
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequence: reset, directed list, random phases with config writes between
  // --------------------------------------------------------------------------

  // engine idle: everything queued has come back as a status transaction
  task automatic wait_idle();
    while (n_results < n_pushed) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_default_attr(logic [ATTR_W-1:0] v);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    mdl_dflt = v;  // current attribute is left alone
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    int unsigned phase_start;
    logic [ATTR_W-1:0] dflt_pick;

    for (int i = 0; i < NCELL; i++) scr_mem[i] = '0;
    mdl_row  = 0;
    mdl_col  = 0;
    mdl_attr = ATTR_RST;
    mdl_dflt = ATTR_RST;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        wait_idle();
        dflt_pick = (ph == 1) ? 8'h00 : (ph == 2) ? 8'hFF : ATTR_W'($urandom());
        write_default_attr(dflt_pick);
      end
      phase_start = n_useful;

      if (ph == 0) begin
        queue_read(0, 0);                         // store is zero after reset
        queue_char(8'h48);
        queue_char(8'h00);                        // character zero is printable
        queue_char(8'hFF);
        queue_op(OP_SET_ATTR, 8'h00, 8'hA5);
        queue_char(CH_TAB);                       // column 3 to 4
        queue_char(CH_BS);
        queue_read(0, 3);                         // blank with new attribute
        queue_char(CH_CR);
        queue_char(CH_BS);                        // top-left, ignored
        queue_char(CH_NL);
        queue_char(CH_BS);                        // back to the end of row 0
        queue_read(0, NCOL - 1);
        queue_read(31, 127);                      // both coordinates off screen
        queue_read(0, NCOL);
        queue_read(NROW, 0);
        queue_cmd(3'd6, 8'hFF, 8'hFF, 5'h1F, 7'h7F);   // unused codes
        queue_cmd(3'd7, 8'h00, 8'h00, 5'h00, 7'h00);
        queue_op(OP_FILL, 8'h00, 8'h00);
        queue_op(OP_FILL, 8'hFF, 8'hFF);
        queue_op(OP_SCROLL_DN, 8'h00, 8'h00);
        queue_read(1, 0);
        queue_op(OP_CLEAR, 8'h00, 8'h00);
        queue_read(NROW - 1, NCOL - 1);
      end else begin
        // each new default takes effect through a clear
        queue_op(OP_CLEAR, CH_W'($urandom()), ATTR_W'($urandom()));
      end

      while (n_useful - phase_start < PHASE_ITEMS) random_episode();
    end

    wait_idle();

    $display("run covered %0d commands over %0d default-attribute settings: ",
             n_pushed, N_PHASES);
    $display("  %0d on-screen reads, %0d scroll-ups, %0d row wraps, %0d results in %0d cycles",
             n_read_hit, n_scroll_up, n_wrap, n_results, n_cycles);

    if (n_errors == 0 && pending_status.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results never arrived", n_errors, pending_status.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tce_pkg.sv
rtl/tce_if.sv
rtl/tce_dp.sv
rtl/tce_ctrl.sv
rtl/text_console_engine_core.sv
dv/tb_top.sv
